>>> design/fsas_pkg.sv
// ----------------------------------------------------------------------------
// fsas_pkg
// Shared types and codes for the float scatter-add store.
// ----------------------------------------------------------------------------
package fsas_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_MOD_SUB,
    ST_READ,
    ST_EXEC,
    ST_WAIT
  } fsas_state_t;

  // request actions
  localparam logic [1:0] ACT_ACC  = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // register select (paddr[2])
  localparam logic REG_BOUNDS = 1'b0;
  localparam logic REG_SIZE   = 1'b1;

  localparam logic [12:0] SIZE_RESET = 13'd4096;

  localparam logic [31:0] F32_QNAN_BIT = 32'h0040_0000;
  localparam logic [31:0] F32_DEF_NAN  = 32'h7FC0_0000;
  localparam logic [30:0] F32_INF_MAG  = 31'h7F80_0000;

endpackage

>>> design/fsas_ram.sv
// ----------------------------------------------------------------------------
// fsas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fsas_fadd.sv
// ----------------------------------------------------------------------------
// fsas_fadd
// Four-stage binary32 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fsas_fadd
  import fsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] sum
);

  // stage A: specials, swap, align
  logic [7:0]  ea, eb, ean, ebn, ebig, esml, d;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb, mbig, msml;
  logic        swap, sbig;
  logic [26:0] ms_full, ms_sh, mask;
  logic        spec;
  logic [31:0] specv;

  logic        a_v, a_sign, a_sub, a_spec;
  logic [9:0]  a_exp;
  logic [26:0] a_mx, a_ms;
  logic [31:0] a_specv;

  always_comb begin
    ea  = a[30:23];
    eb  = b[30:23];
    fa  = a[22:0];
    fb  = b[22:0];
    ma  = {ea != 8'd0, fa};
    mb  = {eb != 8'd0, fb};
    ean = (ea == 8'd0) ? 8'd1 : ea;
    ebn = (eb == 8'd0) ? 8'd1 : eb;
    swap = (ean < ebn) || ((ean == ebn) && (ma < mb));
    ebig = swap ? ebn : ean;
    esml = swap ? ean : ebn;
    mbig = swap ? mb : ma;
    msml = swap ? ma : mb;
    sbig = swap ? b[31] : a[31];
    d    = ebig - esml;
    ms_full = {msml, 3'b000};
    mask    = '0;
    if (d >= 8'd27) begin
      ms_sh = {26'd0, |msml};
    end else begin
      mask  = ~({27{1'b1}} << d[4:0]);
      ms_sh = (ms_full >> d[4:0]) | {26'd0, |(ms_full & mask)};
    end
    spec  = 1'b1;
    specv = '0;
    if (ea == 8'hFF && fa != 23'd0) begin
      specv = a | F32_QNAN_BIT;
    end else if (eb == 8'hFF && fb != 23'd0) begin
      specv = b | F32_QNAN_BIT;
    end else if (ea == 8'hFF) begin
      specv = (eb == 8'hFF && a[31] != b[31]) ? F32_DEF_NAN : a;
    end else if (eb == 8'hFF) begin
      specv = b;
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= in_valid;
    end
    a_sign  <= sbig;
    a_sub   <= a[31] ^ b[31];
    a_exp   <= {2'b00, ebig};
    a_mx    <= {mbig, 3'b000};
    a_ms    <= ms_sh;
    a_spec  <= spec;
    a_specv <= specv;
  end

  // stage B: add or subtract
  logic [27:0] s28;
  logic [26:0] bm;
  logic [9:0]  bexp;
  logic        b_v, b_sign, b_spec;
  logic [9:0]  b_exp;
  logic [26:0] b_m;
  logic [31:0] b_specv;

  always_comb begin
    s28  = a_sub ? ({1'b0, a_mx} - {1'b0, a_ms}) : ({1'b0, a_mx} + {1'b0, a_ms});
    bm   = s28[26:0];
    bexp = a_exp;
    if (s28[27]) begin
      bm   = {s28[27:2], s28[1] | s28[0]};
      bexp = a_exp + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
    b_sign  <= a_sign;
    b_exp   <= bexp;
    b_m     <= bm;
    // exact cancellation gives +0.0
    b_spec  <= a_spec || (a_sub && s28 == 28'd0);
    b_specv <= a_spec ? a_specv : 32'd0;
  end

  // stage C: leading-zero count, clamped so the exponent stays at least 1
  logic [4:0] lz, shc;
  logic [9:0] lim;
  logic        c_v, c_sign, c_spec;
  logic [9:0]  c_exp;
  logic [26:0] c_m;
  logic [4:0]  c_sh;
  logic [31:0] c_specv;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (b_m[i]) lz = 5'(26 - i);
    end
    lim = b_exp - 10'd1;
    shc = ({5'd0, lz} > lim) ? lim[4:0] : lz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b_v;
    end
    c_sign  <= b_sign;
    c_exp   <= b_exp;
    c_m     <= b_m;
    c_sh    <= shc;
    c_spec  <= b_spec;
    c_specv <= b_specv;
  end

  // stage D: normalise, round, pack
  logic [26:0] mn;
  logic [9:0]  en;
  logic [24:0] r;
  logic [2:0]  rem;
  logic        inc;
  logic [31:0] res;

  always_comb begin
    mn  = c_m << c_sh;
    en  = c_exp - {5'd0, c_sh};
    rem = mn[2:0];
    inc = (rem > 3'd4) || (rem == 3'd4 && mn[3]);
    r   = {1'b0, mn[26:3]} + {24'd0, inc};
    if (r[24]) begin
      r  = r >> 1;
      en = en + 10'd1;
    end
    if (c_spec) begin
      res = c_specv;
    end else if (en >= 10'd255) begin
      res = {c_sign, F32_INF_MAG};
    end else begin
      res = {c_sign, (r[23] ? en[7:0] : 8'd0), r[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_v;
    end
    sum <= res;
  end

endmodule

>>> design/float_scatter_add_store.sv
// ----------------------------------------------------------------------------
// float_scatter_add_store
// Binary32 store with accumulate, load and read requests by signed index.
// ----------------------------------------------------------------------------
// Steps: read/load go through read and execute; accumulate goes through read,
//   memory data, four adder stages and write-back; with checking off and a DEPTH
//   that is not a power of two, the index reduction (multiply, subtract) comes first.
// Requests: one at a time; busy drops as done rises, so a new request
//   is taken only once the last one is done.
// Reset: rst is synchronous; afterwards a clearing pass writes +0.0 to every
//   entry, one per cycle, with busy high. Config writes go on.
// The receiver cannot stall: done is high for one cycle per request.
module float_scatter_add_store
  import fsas_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic signed [31:0] index,
  input  logic [31:0] value,
  input  logic        last_pair,
  // result
  output logic        done,
  output logic [31:0] entry_value,
  output logic        bounds_error,
  output logic        batch_done,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam bit IS_POW2 = (DEPTH & (DEPTH - 1)) == 0;
  // ceil(2^(32+AW) / DEPTH): exact quotient for any 32-bit index
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + AW)) + 64'(DEPTH - 1)) / 64'(DEPTH));

  // --- configuration registers ---
  logic        bounds_check;
  logic [12:0] array_size;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds_check <= 1'b0;
      array_size   <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BOUNDS: bounds_check <= pwdata[0];
        REG_SIZE:   array_size   <= pwdata[12:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BOUNDS: prdata = {31'd0, bounds_check};
      REG_SIZE:   prdata = {19'd0, array_size};
      default:    prdata = '0;
    endcase
  end

  // --- bounds check: limit is array_size capped at DEPTH ---
  logic [31:0] size32, limit32;
  logic        in_range;

  assign size32   = {19'd0, array_size};
  assign limit32  = (size32 > 32'(DEPTH)) ? 32'(DEPTH) : size32;
  assign in_range = index < limit32;   // negative indices read as huge

  // --- request registers ---
  fsas_state_t state, state_next;
  logic [1:0]  act;
  logic [31:0] val;
  logic        last;
  logic        err;
  logic [AW-1:0] slot;
  logic [AW-1:0] clr_addr;
  // reduction modulo DEPTH: quotient by reciprocal multiply, then subtract
  logic [31:0]   idx_u;
  logic [31:0]   quot;
  logic [64:0]   recip_prod;
  logic [31:0]   back_prod;
  logic [AW-1:0] mod_slot;

  assign recip_prod = 65'(idx_u) * 65'(RECIP);
  assign back_prod  = quot * 32'(DEPTH);
  assign mod_slot   = AW'(idx_u - back_prod);

  logic        accept;
  assign accept = start && !busy;

  // --- store and adder ---
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          add_go, add_done;
  logic [31:0]   add_sum;
  logic          emit;
  logic [31:0]   emit_val;

  fsas_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (slot),
    .rdata (mem_rdata)
  );

  fsas_fadd u_fadd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (add_go),
    .a         (mem_rdata),
    .b         (val),
    .out_valid (add_done),
    .sum       (add_sum)
  );

  // --- sequencer: next state ---
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_next = (!IS_POW2 && !bounds_check) ? ST_MOD : ST_READ;
        end
      end
      ST_MOD:     state_next = ST_MOD_SUB;
      ST_MOD_SUB: state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = (!err && act == ACT_ACC) ? ST_WAIT : ST_IDLE;
      ST_WAIT: if (add_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // --- sequencer: outputs ---
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot;
    mem_wdata = val;
    add_go    = 1'b0;
    emit      = 1'b0;
    emit_val  = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: busy = 1'b0;
      ST_READ: mem_re = 1'b1;
      ST_EXEC: begin
        if (err) begin
          emit = 1'b1;
        end else begin
          case (act)
            ACT_ACC:  add_go = 1'b1;
            ACT_LOAD: begin
              mem_we   = 1'b1;
              emit     = 1'b1;
              emit_val = val;
            end
            default: begin   // read, and the unused code acts as read
              emit     = 1'b1;
              emit_val = mem_rdata;
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (add_done) begin
          mem_we    = 1'b1;
          mem_wdata = add_sum;
          emit      = 1'b1;
          emit_val  = add_sum;
        end
      end
      default: ;
    endcase
  end

  // --- registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
    if (accept) begin
      act   <= action;
      val   <= value;
      last  <= last_pair;
      err   <= bounds_check && !in_range;
      slot  <= index[AW-1:0];
      idx_u <= index;
    end else if (state == ST_MOD) begin
      quot  <= 32'(recip_prod >> (32 + AW));
    end else if (state == ST_MOD_SUB) begin
      slot  <= mod_slot;
    end
    entry_value  <= emit_val;
    bounds_error <= err;
    batch_done   <= last;
  end

`ifndef SYNTHESIS
  a_one_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe on two cycles in a row");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_IDLE && mem_we))
    else $error("store written while idle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bounds_error) |-> (entry_value == 32'd0))
    else $error("rejected request returned a non-zero value");
  a_add_in_wait: assert property (@(posedge clk) disable iff (rst)
    add_done |-> (state == ST_WAIT))
    else $error("adder result outside wait state");
`endif

endmodule
